[rtl/sqr_pkg.sv]
// Shared constants, payload types and status codes for the quadratic root solver.
package sqr_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // Derived datapath widths
    localparam int PROD_W    = 2 * COEF_WIDTH;
    localparam int DISC_W    = PROD_W + 1;
    localparam int SQ_STEPS  = (DISC_W + 1) / 2;
    localparam int RAD_W     = 2 * SQ_STEPS;
    localparam int ROOT_W    = SQ_STEPS;
    localparam int SQ_REM_W  = ROOT_W + 2;
    localparam int T_W       = ROOT_W + 1;
    localparam int DEN_W     = T_W;
    localparam int NUM_W     = T_W + FRAC_BITS;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_COMPLEX = 2'd1;
    localparam logic [1:0] ST_AZERO   = 2'd2;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] coef_quad;
        logic signed [COEF_WIDTH-1:0] coef_lin;
        logic signed [COEF_WIDTH-1:0] coef_const;
    } t_req;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] root_first;
        logic signed [COEF_WIDTH-1:0] root_second;
        logic [1:0]                   status;
        logic                         saturated;
    } t_rsp;

    // Per-request sideband that travels with the pipeline
    typedef struct packed {
        logic [1:0]            status;
        logic                  an;
        logic                  bn;
        logic                  cn;
        logic                  tneg;
        logic [COEF_WIDTH-1:0] am;
        logic [COEF_WIDTH-1:0] bm;
        logic [COEF_WIDTH-1:0] cm;
        logic [T_W-1:0]        tm;
    } t_meta;

endpackage

[rtl/sqr_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module sqr_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [sqr_pkg::DISC_W-1:0]  i_disc,
    input  sqr_pkg::t_meta              i_meta,
    output logic                        o_valid,
    output logic [sqr_pkg::ROOT_W-1:0]  o_root,
    output sqr_pkg::t_meta              o_meta
);
    import sqr_pkg::*;

    logic [SQ_REM_W-1:0] s_rem  [SQ_STEPS+1];
    logic [ROOT_W-1:0]   s_root [SQ_STEPS+1];
    logic [RAD_W-1:0]    s_rad  [SQ_STEPS+1];
    logic                s_vld  [SQ_STEPS+1];
    t_meta               s_meta [SQ_STEPS+1];

    // Feed the first stage
    assign s_rem[0]  = '0;
    assign s_root[0] = '0;
    assign s_rad[0]  = RAD_W'(i_disc);
    assign s_vld[0]  = i_valid;
    assign s_meta[0] = i_meta;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        logic [SQ_REM_W+1:0] w_cat;
        logic [SQ_REM_W+1:0] w_try;
        logic [SQ_REM_W+1:0] w_diff;
        logic                w_ge;
        logic [SQ_REM_W-1:0] r_rem;
        logic [ROOT_W-1:0]   r_root;
        logic [RAD_W-1:0]    r_rad;
        logic                r_vld;
        t_meta               r_meta;

        // Bring down two radicand bits and try the next root bit
        assign w_cat  = {s_rem[k], s_rad[k][RAD_W-1 -: 2]};
        assign w_try  = (SQ_REM_W+2)'({s_root[k], 2'b01});
        assign w_ge   = (w_cat >= w_try);
        assign w_diff = w_cat - w_try;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_cat[SQ_REM_W-1:0];
                r_root <= {s_root[k][ROOT_W-2:0], w_ge};
                r_rad  <= {s_rad[k][RAD_W-3:0], 2'b00};
                r_meta <= s_meta[k];
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_root[k+1] = r_root;
        assign s_rad[k+1]  = r_rad;
        assign s_vld[k+1]  = r_vld;
        assign s_meta[k+1] = r_meta;
    end

    assign o_valid = s_vld[SQ_STEPS];
    assign o_root  = s_root[SQ_STEPS];
    assign o_meta  = s_meta[SQ_STEPS];

endmodule

[rtl/sqr_div.sv]
// Pipelined unsigned restoring divider, one quotient bit per stage.
module sqr_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [sqr_pkg::NUM_W-1:0]  i_num,
    input  logic [sqr_pkg::DEN_W-1:0]  i_den,
    input  sqr_pkg::t_meta             i_meta,
    output logic                       o_valid,
    output logic [sqr_pkg::NUM_W-1:0]  o_quo,
    output sqr_pkg::t_meta             o_meta
);
    import sqr_pkg::*;

    logic [DEN_W-1:0] s_rem  [NUM_W+1];
    logic [NUM_W-1:0] s_quo  [NUM_W+1];
    logic [NUM_W-1:0] s_num  [NUM_W+1];
    logic [DEN_W-1:0] s_den  [NUM_W+1];
    logic             s_vld  [NUM_W+1];
    t_meta            s_meta [NUM_W+1];

    // Feed the first stage
    assign s_rem[0]  = '0;
    assign s_quo[0]  = '0;
    assign s_num[0]  = i_num;
    assign s_den[0]  = i_den;
    assign s_vld[0]  = i_valid;
    assign s_meta[0] = i_meta;

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W:0]   w_cat;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [DEN_W-1:0] r_rem;
        logic [NUM_W-1:0] r_quo;
        logic [NUM_W-1:0] r_num;
        logic [DEN_W-1:0] r_den;
        logic             r_vld;
        t_meta            r_meta;

        // Shift in the next numerator bit and subtract when it fits
        assign w_cat  = {s_rem[k], s_num[k][NUM_W-1]};
        assign w_ge   = (w_cat >= {1'b0, s_den[k]});
        assign w_diff = w_cat - {1'b0, s_den[k]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_en) begin
                r_vld <= s_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_cat[DEN_W-1:0];
                r_quo  <= {s_quo[k][NUM_W-2:0], w_ge};
                r_num  <= {s_num[k][NUM_W-2:0], 1'b0};
                r_den  <= s_den[k];
                r_meta <= s_meta[k];
            end
        end

        assign s_rem[k+1]  = r_rem;
        assign s_quo[k+1]  = r_quo;
        assign s_num[k+1]  = r_num;
        assign s_den[k+1]  = r_den;
        assign s_vld[k+1]  = r_vld;
        assign s_meta[k+1] = r_meta;
    end

    assign o_valid = s_vld[NUM_W];
    assign o_quo   = s_quo[NUM_W];
    assign o_meta  = s_meta[NUM_W];

endmodule

[rtl/stable_quadratic_roots_top.sv]
// Top level: quadratic roots by the cancellation-free formula, fully pipelined.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_req  (t_req)
//  result    out        o_valid / i_ready    o_rsp  (t_rsp)
//  config    in         i_cfg_we             i_cfg_wdata (force_real)
//
// One request enters per cycle while the result side is not stalled; each passes
// 3 + 33 + 1 + 50 + 1 = 88 register stages: input split, multiply, discriminant, one
// square-root stage per root bit (33), sum stage, one divider stage per quotient bit
// (50), and the output register.
// Reset is synchronous, active low, and clears all valid bits and force_real.
// A stall on the result side freezes every stage at once; nothing is lost.
module stable_quadratic_roots_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sqr_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output sqr_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);
    import sqr_pkg::*;

    localparam int CW = COEF_WIDTH;

    logic                  w_en;
    logic                  r_force_real;

    logic                  r_s0_vld;
    t_meta                 r_s0_meta;
    t_meta                 n_s0_meta;

    logic                  r_s1_vld;
    t_meta                 r_s1_meta;
    logic [PROD_W-1:0]     r_s1_b2;
    logic [PROD_W-1:0]     r_s1_ac;

    logic                  r_s2_vld;
    t_meta                 r_s2_meta;
    logic [DISC_W-1:0]     r_s2_disc;
    logic [PROD_W+1:0]     w_ac4;
    logic [PROD_W+1:0]     w_b2x;
    logic [PROD_W+1:0]     w_disc;
    logic                  w_dneg;
    t_meta                 n_s2_meta;

    logic                  w_sq_vld;
    logic [ROOT_W-1:0]     w_sq_root;
    t_meta                 w_sq_meta;

    logic                  r_t_vld;
    t_meta                 r_t_meta;
    t_meta                 n_t_meta;

    logic                  w_dv_vld;
    logic [NUM_W-1:0]      w_q1;
    logic [NUM_W-1:0]      w_q2;
    t_meta                 w_dv_meta;
    logic                  w_dv2_vld;
    t_meta                 w_dv2_meta;

    logic [CW:0]           w_prim;
    logic [CW:0]           w_other;
    t_rsp                  n_out;
    logic                  r_out_vld;
    t_rsp                  r_out;

    // Saturate a quotient magnitude and apply its sign: {sat, code}
    function automatic logic [CW:0] f_encode(input logic neg, input logic [NUM_W-1:0] q);
        logic [NUM_W-1:0] lim;
        logic [NUM_W-1:0] m;
        logic             sat;
        lim = neg ? (NUM_W'(1) << (CW - 1)) : ((NUM_W'(1) << (CW - 1)) - NUM_W'(1));
        sat = (q > lim);
        m   = sat ? lim : q;
        return {sat, neg ? (~m[CW-1:0] + CW'(1)) : m[CW-1:0]};
    endfunction

    // Advance the whole pipe when the output register is free or drained
    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // Hold the configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_force_real <= 1'b0;
        end else if (i_cfg_we) begin
            r_force_real <= i_cfg_wdata;
        end
    end

    // Stage 0: split coefficients into sign and magnitude
    always_comb begin
        n_s0_meta        = '0;
        n_s0_meta.an     = i_req.coef_quad[CW-1];
        n_s0_meta.bn     = i_req.coef_lin[CW-1];
        n_s0_meta.cn     = i_req.coef_const[CW-1];
        n_s0_meta.am     = n_s0_meta.an ? (~i_req.coef_quad + CW'(1)) : i_req.coef_quad;
        n_s0_meta.bm     = n_s0_meta.bn ? (~i_req.coef_lin + CW'(1)) : i_req.coef_lin;
        n_s0_meta.cm     = n_s0_meta.cn ? (~i_req.coef_const + CW'(1)) : i_req.coef_const;
    end

    // Stage 1: products b*b and a*c
    // Stage 2: discriminant and status
    always_comb begin
        w_ac4  = {r_s1_ac, 2'b00};
        w_b2x  = {2'b00, r_s1_b2};
        w_dneg = (r_s1_meta.an == r_s1_meta.cn) && (w_ac4 > w_b2x);
        if (r_s1_meta.an != r_s1_meta.cn) begin
            w_disc = w_b2x + w_ac4;
        end else if (w_dneg) begin
            w_disc = '0;
        end else begin
            w_disc = w_b2x - w_ac4;
        end
        n_s2_meta = r_s1_meta;
        if (r_s1_meta.am == '0) begin
            n_s2_meta.status = ST_AZERO;
        end else if (w_dneg && !r_force_real) begin
            n_s2_meta.status = ST_COMPLEX;
        end else begin
            n_s2_meta.status = ST_OK;
        end
    end

    // Valid bits for the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_t_vld  <= 1'b0;
        end else if (w_en) begin
            r_s0_vld <= i_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_t_vld  <= w_sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_meta <= n_s0_meta;
            r_s1_meta <= r_s0_meta;
            r_s1_b2   <= PROD_W'(r_s0_meta.bm) * PROD_W'(r_s0_meta.bm);
            r_s1_ac   <= PROD_W'(r_s0_meta.am) * PROD_W'(r_s0_meta.cm);
            r_s2_meta <= n_s2_meta;
            r_s2_disc <= w_disc[DISC_W-1:0];
            r_t_meta  <= n_t_meta;
        end
    end

    // Square root of the discriminant
    sqr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_s2_vld),
        .i_disc  (r_s2_disc),
        .i_meta  (r_s2_meta),
        .o_valid (w_sq_vld),
        .o_root  (w_sq_root),
        .o_meta  (w_sq_meta)
    );

    // Sum stage: t magnitude and sign
    always_comb begin
        n_t_meta      = w_sq_meta;
        n_t_meta.tm   = T_W'(w_sq_meta.bm) + T_W'(w_sq_root);
        n_t_meta.tneg = !w_sq_meta.bn && (n_t_meta.tm != '0);
    end

    // t / (2a)
    sqr_div u_div_prim (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t_vld),
        .i_num   ({r_t_meta.tm, {FRAC_BITS{1'b0}}}),
        .i_den   (DEN_W'({r_t_meta.am, 1'b0})),
        .i_meta  (r_t_meta),
        .o_valid (w_dv_vld),
        .o_quo   (w_q1),
        .o_meta  (w_dv_meta)
    );

    // 2c / t
    sqr_div u_div_other (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_t_vld),
        .i_num   (NUM_W'({r_t_meta.cm, 1'b0, {FRAC_BITS{1'b0}}})),
        .i_den   (r_t_meta.tm),
        .i_meta  (r_t_meta),
        .o_valid (w_dv2_vld),
        .o_quo   (w_q2),
        .o_meta  (w_dv2_meta)
    );

    // Encode, saturate and order the roots
    always_comb begin
        w_prim  = f_encode(w_dv_meta.tneg != w_dv_meta.an, w_q1);
        w_other = (w_dv_meta.tm == '0) ? w_prim
                : f_encode(w_dv2_meta.cn != w_dv2_meta.tneg, w_q2);
        n_out   = '0;
        n_out.status = w_dv_meta.status;
        if (w_dv_meta.status == ST_OK) begin
            n_out.saturated = w_prim[CW] | w_other[CW];
            if (!w_dv_meta.bn) begin
                n_out.root_first  = w_prim[CW-1:0];
                n_out.root_second = w_other[CW-1:0];
            end else begin
                n_out.root_first  = w_other[CW-1:0];
                n_out.root_second = w_prim[CW-1:0];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld && w_dv2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

endmodule

[rtl/sqr_checker.sv]
// Port-level checker for the quadratic root solver, bound to the top level.
module sqr_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_ready,
    input logic          o_valid,
    input logic          i_ready,
    input sqr_pkg::t_rsp o_rsp
);
    import sqr_pkg::*;

    // Drop results during reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("stalled result changed");

    // Roots are zero on any non-ok status
    a_zero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.status != ST_OK |->
            o_rsp.root_first == '0 && o_rsp.root_second == '0 && !o_rsp.saturated)
        else $error("roots not cleared for non-ok status");

    // Accept requests exactly when the output slot can move
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (!o_valid || i_ready))
        else $error("request ready does not follow output slot");

endmodule

bind stable_quadratic_roots_top sqr_checker u_sqr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

[tb/stable_quadratic_roots_top_tb.sv]
// Self-checking testbench for the quadratic root solver: directed table plus random requests.
module stable_quadratic_roots_top_tb;
    import sqr_pkg::*;

    localparam int HOLD_CYCLES = 100;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_REQS  = 240;

    typedef struct {
        logic  frc;
        t_req  req;
        logic  typed;
        t_rsp  rsp;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_req i_req = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_rsp o_rsp;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    t_rsp roots_due[$];
    t_row rows[$];
    logic force_real_mdl = 1'b0;
    int   send_idle = 0;
    int   recv_stall = 0;
    int   err_cnt = 0;
    int   quiet_cycles = 0;

    stable_quadratic_roots_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_req(i_req),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_rsp),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Signed quotient (num << FRAC_BITS) / den, clipped to the root range
    function automatic logic [COEF_WIDTH:0] div_code(logic [63:0] num, logic [63:0] den,
                                                     logic neg);
        logic [127:0] q;
        logic [127:0] lim;
        logic         clip;
        logic [COEF_WIDTH-1:0] code;
        q    = ({64'b0, num} << FRAC_BITS) / {64'b0, den};
        lim  = neg ? (128'd1 << (COEF_WIDTH - 1)) : (128'd1 << (COEF_WIDTH - 1)) - 1;
        clip = q > lim;
        if (clip) q = lim;
        code = neg ? -q[COEF_WIDTH-1:0] : q[COEF_WIDTH-1:0];
        return {clip, code};
    endfunction

    // Expected result for one request under the given force_real setting
    function automatic t_rsp solve_roots(t_req r, logic frc);
        logic an, bn, cn, dneg, tneg;
        logic [COEF_WIDTH-1:0] am, bm, cm;
        logic [127:0] b2, ac4, disc, cand;
        logic [63:0] d, tm;
        logic [COEF_WIDTH:0] prim, other;
        t_rsp o;
        o  = '0;
        an = r.coef_quad[COEF_WIDTH-1];
        bn = r.coef_lin[COEF_WIDTH-1];
        cn = r.coef_const[COEF_WIDTH-1];
        am = an ? -r.coef_quad : r.coef_quad;
        bm = bn ? -r.coef_lin : r.coef_lin;
        cm = cn ? -r.coef_const : r.coef_const;
        if (am == 0) begin
            o.status = ST_AZERO;
            return o;
        end
        b2   = {96'b0, bm} * {96'b0, bm};
        ac4  = ({96'b0, am} * {96'b0, cm}) << 2;
        disc = '0;
        dneg = 1'b0;
        if (an != cn) disc = b2 + ac4;
        else if (ac4 > b2) dneg = 1'b1;
        else disc = b2 - ac4;
        if (dneg && !frc) begin
            o.status = ST_COMPLEX;
            return o;
        end
        // Integer square root, one bit per step
        d = '0;
        for (int bit_i = 63; bit_i >= 0; bit_i--) begin
            cand = {64'b0, d | (64'd1 << bit_i)};
            if (cand * cand <= disc) d = cand[63:0];
        end
        tm    = {32'b0, bm} + d;
        tneg  = !bn && (tm != 0);
        prim  = div_code(tm, {32'b0, am} << 1, tneg != an);
        other = (tm == 0) ? prim : div_code({32'b0, cm} << 1, tm, cn != tneg);
        o.status      = ST_OK;
        o.saturated   = prim[COEF_WIDTH] | other[COEF_WIDTH];
        o.root_first  = bn ? other[COEF_WIDTH-1:0] : prim[COEF_WIDTH-1:0];
        o.root_second = bn ? prim[COEF_WIDTH-1:0] : other[COEF_WIDTH-1:0];
        return o;
    endfunction

    // Coefficient mix: small values reach real roots, full range hits saturation
    function automatic logic [COEF_WIDTH-1:0] pick_coef();
        case ($urandom_range(9))
            0: return '0;
            1: return {1'b1, {(COEF_WIDTH-1){1'b0}}};
            2: return {1'b0, {(COEF_WIDTH-1){1'b1}}};
            3, 4: return $urandom;
            5, 6: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            default: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
        endcase
    endfunction

    // Append one row to the directed table
    function automatic void add_row(logic frc, t_req req, logic typed, t_rsp rsp);
        t_row row;
        row = '{frc, req, typed, rsp};
        rows.insert(rows.size(), row);
    endfunction

    task automatic report_mismatch(string what, logic [COEF_WIDTH-1:0] got,
                                   logic [COEF_WIDTH-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        err_cnt++;
    endtask

    // Receiver: random stall, compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_rsp want;
        i_ready <= ($urandom_range(99) >= recv_stall);
        if (i_rst_n && o_valid && i_ready) begin
            if (roots_due.size() == 0) begin
                report_mismatch("unexpected result", o_rsp.root_first, '0);
            end else begin
                want = roots_due.pop_front();
                if (o_rsp.root_first !== want.root_first)
                    report_mismatch("root_first", o_rsp.root_first, want.root_first);
                if (o_rsp.root_second !== want.root_second)
                    report_mismatch("root_second", o_rsp.root_second, want.root_second);
                if (o_rsp.status !== want.status)
                    report_mismatch("status", COEF_WIDTH'(o_rsp.status),
                                    COEF_WIDTH'(want.status));
                if (o_rsp.saturated !== want.saturated)
                    report_mismatch("saturated", COEF_WIDTH'(o_rsp.saturated),
                                    COEF_WIDTH'(want.saturated));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Hold until every result is back, then let the pipeline empty
    task automatic drain();
        while (roots_due.size() != 0) @(posedge i_clk);
        repeat (HOLD_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_force(logic v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        force_real_mdl = v;
    endtask

    // Present one request, idle first at random, queue its expectation on acceptance
    task automatic send_req(t_req r, logic typed, t_rsp rsp);
        if (send_idle != 0 && $urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
        roots_due.insert(roots_due.size(), typed ? rsp : solve_roots(r, force_real_mdl));
    endtask

    initial begin
        t_row row;
        t_req r;
        t_rsp azero_rsp;
        t_rsp cplx_rsp;
        azero_rsp = '{root_first: '0, root_second: '0, status: ST_AZERO, saturated: 1'b0};
        cplx_rsp  = '{root_first: '0, root_second: '0, status: ST_COMPLEX, saturated: 1'b0};

        // Directed table: zero leading coefficient, complex, forced real, zero t, extremes
        add_row(1'b0, t_req'{32'h0, 32'h0001_0000, 32'h0001_0000}, 1'b1, azero_rsp);
        add_row(1'b0, t_req'{32'h0, 32'h8000_0000, 32'h7fff_ffff}, 1'b1, azero_rsp);
        add_row(1'b0, t_req'{32'h0001_0000, 32'h0, 32'h0001_0000}, 1'b1, cplx_rsp);
        add_row(1'b0, t_req'{32'hffff_0000, 32'h0, 32'hffff_0000}, 1'b1, cplx_rsp);
        add_row(1'b0, t_req'{32'h0001_0000, 32'hfffd_0000, 32'h0002_0000}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h0001_0000, 32'h0002_0000, 32'h0001_0000}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h0001_0000, 32'h0, 32'h0}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h0001_0000, 32'h0, 32'hfffc_0000}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h0000_0001, 32'h7fff_ffff, 32'h7fff_ffff}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0);
        add_row(1'b0, t_req'{32'h8000_0000, 32'h0000_0001, 32'hffff_ffff}, 1'b0, '0);
        add_row(1'b1, t_req'{32'h0001_0000, 32'h0, 32'h0001_0000}, 1'b0, '0);
        add_row(1'b1, t_req'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}, 1'b0, '0);
        add_row(1'b1, t_req'{32'hffff_0000, 32'hffff_0000, 32'hffff_0000}, 1'b0, '0);
        add_row(1'b1, t_req'{32'h7fff_ffff, 32'h0, 32'h7fff_ffff}, 1'b0, '0);
        add_row(1'b1, t_req'{32'h0, 32'h0, 32'h0}, 1'b1, azero_rsp);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            row = rows[i];
            if (row.frc != force_real_mdl) begin
                i_valid <= 1'b0;
                write_force(row.frc);
            end
            send_req(row.req, row.typed, row.rsp);
        end

        // Random phases: idling mode by pair, force_real alternating
        for (int ph = 0; ph < 8; ph++) begin
            i_valid <= 1'b0;
            write_force(ph[0]);
            case (ph / 2)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 84; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 84; end
                default: begin send_idle = 22; recv_stall = 22; end
            endcase
            for (int n = 0; n < PHASE_REQS; n++) begin
                if (ph == 3 && n == PHASE_REQS / 2) begin
                    i_valid <= 1'b0;
                    drain();
                end
                r.coef_quad  = pick_coef();
                r.coef_lin   = pick_coef();
                r.coef_const = pick_coef();
                send_req(r, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        drain();
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[files.f]
rtl/sqr_pkg.sv
rtl/sqr_sqrt.sv
rtl/sqr_div.sv
rtl/stable_quadratic_roots_top.sv
rtl/sqr_checker.sv
tb/stable_quadratic_roots_top_tb.sv
